// File: hdl/rrs_pkg.sv
package rrs_pkg;

    // Candidate ids, row width and count width are fixed by the item format
    localparam int ID_W  = 5;
    localparam int ROWS  = 32;
    localparam int CNT_W = 6;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_CHECK = 2'd2,
        OP_EMIT  = 2'd3
    } t_op;

    // Controller to datapath commands
    typedef struct packed {
        logic            take;       // input item accepted, latch the pair
        logic            rd_en;      // launch row reads
        logic            scan_sel;   // read address comes from the scan index
        logic [ID_W-1:0] scan_id;
        logic            clear;      // drop all rows and the present mask
        logic            add_wr;     // write back the merged rows
        logic            emit_init;  // clear slot table and incomplete flag
        logic            out_chk;    // load the check result
        logic            out_slot;   // load one order slot
        logic [ID_W-1:0] slot;
        logic            slot_last;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_free;   // output register empty or being taken
        logic pipe_busy;  // scan pipeline still holds rows
    } t_sts;

    function automatic logic [CNT_W-1:0] pop_count(input logic [ROWS-1:0] v);
        logic [CNT_W-1:0] s [ROWS];
        for (int i = 0; i < ROWS; i++) begin
            s[i] = CNT_W'(v[i]);
        end
        // pairwise adder tree, five levels for 32 bits
        for (int w = ROWS >> 1; w >= 1; w = w >> 1) begin
            for (int i = 0; i < w; i++) begin
                s[i] = s[2*i] + s[2*i+1];
            end
        end
        return s[0];
    endfunction

endpackage

// File: hdl/ranking_relation_store_unit.sv
// Ranking relation store. Holds, for up to 32 candidates, a row of candidates known to rank
// below and a row known to rank above, plus a present mask. Commands arrive on the slave
// stream (tuser = command): clear acts when it is accepted, add relation does a row read and
// then a merged row write, and check pair does a row read and then returns one item. Emit
// order walks all 32 rows through one read port of each row memory, one row per cycle, then
// drains the scan pipeline, then streams the effective count of slot items from the highest
// slot down, one per cycle when the master side is ready. Rows reset and clear through
// per-row valid bits, so no clearing pass follows reset. New commands are taken while an
// earlier result still waits in the output register. candidate_count sits at byte address
// 0; it is clamped to MAX_CANDIDATES and 32, and zero counts as one.
module ranking_relation_store_unit #(
    parameter int MAX_CANDIDATES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [4:0] lower_id, [9:5] upper_id, [15:10] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] conform, [5:1] order_candidate,
                                        // [6] slot_filled, [7] incomplete
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rrs_pkg::*;

    localparam int LIM = (MAX_CANDIDATES < ROWS) ? MAX_CANDIDATES : ROWS;
    localparam logic [CNT_W-1:0] LIM_CNT = CNT_W'(LIM);

    logic [CNT_W-1:0] r_candidate_count;
    logic [CNT_W-1:0] eff_cnt;
    logic             cfg_wr;
    t_cmd             cmd;
    t_sts             sts;
    logic             conform, slot_filled, incomplete;
    logic [ID_W-1:0]  order_candidate;

    // Config register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_candidate_count <= CNT_W'(ROWS);
        end else if (cfg_wr) begin
            r_candidate_count <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, r_candidate_count} : '0;

    // Effective count
    always_comb begin
        if (r_candidate_count == '0)         eff_cnt = CNT_W'(1);
        else if (r_candidate_count > LIM_CNT) eff_cnt = LIM_CNT;
        else                                  eff_cnt = r_candidate_count;
    end

    rrs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_op       (t_op'(s_axis_tuser)),
        .i_cnt      (eff_cnt),
        .i_sts      (sts),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    rrs_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_lower_id        (s_axis_tdata[4:0]),
        .i_upper_id        (s_axis_tdata[9:5]),
        .i_cnt             (eff_cnt),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .o_m_valid         (m_axis_tvalid),
        .i_m_ready         (m_axis_tready),
        .o_conform         (conform),
        .o_order_candidate (order_candidate),
        .o_slot_filled     (slot_filled),
        .o_incomplete      (incomplete),
        .o_last            (m_axis_tlast)
    );

    assign m_axis_tdata = {incomplete, slot_filled, order_candidate, conform};

    // A conforming result only comes from a check: single, last, no slot fields
    a_conform_is_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[0]) |-> (m_axis_tlast && m_axis_tdata[7:1] == 7'd0))
        else $error("conforming result carries slot fields");

    // Empty slot shows candidate zero
    a_empty_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[6]) |-> (m_axis_tdata[5:1] == 5'd0))
        else $error("empty slot with nonzero candidate");

    // No command is taken while the row scan is still in flight
    a_scan_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sts.pipe_busy |-> !s_axis_tready)
        else $error("item accepted during row scan");

    // A taken clear leaves nothing of the scan behind on the next cycle
    a_clear_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.clear) |=> !sts.pipe_busy)
        else $error("scan pipeline active after clear");

endmodule

// File: hdl/rrs_ctrl.sv
module rrs_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  rrs_pkg::t_op                  i_op,
    input  logic [rrs_pkg::CNT_W-1:0]     i_cnt,
    input  rrs_pkg::t_sts                 i_sts,
    output logic                          o_in_ready,
    output rrs_pkg::t_cmd                 o_cmd
);
    import rrs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADD,
        S_CHK,
        S_SCAN,
        S_DRAIN,
        S_OUT
    } t_state;

    t_state          r_state;
    logic [ID_W-1:0] r_idx;
    logic [ID_W-1:0] r_slot;
    logic            accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = o_in_ready && i_in_valid;

    // Command decode
    always_comb begin
        o_cmd           = '0;
        o_cmd.take      = accept;
        o_cmd.rd_en     = accept || (r_state == S_SCAN);
        o_cmd.scan_sel  = (r_state == S_SCAN);
        o_cmd.scan_id   = r_idx;
        o_cmd.clear     = accept && (i_op == OP_CLEAR);
        o_cmd.add_wr    = (r_state == S_ADD);
        o_cmd.emit_init = accept && (i_op == OP_EMIT);
        o_cmd.out_chk   = (r_state == S_CHK) && i_sts.out_free;
        o_cmd.out_slot  = (r_state == S_OUT) && i_sts.out_free;
        o_cmd.slot      = r_slot;
        o_cmd.slot_last = (r_slot == '0);
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_slot  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        unique case (i_op)
                            OP_CLEAR: r_state <= S_IDLE;
                            OP_ADD:   r_state <= S_ADD;
                            OP_CHECK: r_state <= S_CHK;
                            OP_EMIT: begin
                                r_state <= S_SCAN;
                                r_idx   <= '0;
                            end
                            default:  r_state <= S_IDLE;
                        endcase
                    end
                end
                S_ADD: r_state <= S_IDLE;
                S_CHK: begin
                    if (i_sts.out_free) r_state <= S_IDLE;
                end
                S_SCAN: begin
                    r_idx <= r_idx + 1'b1;
                    if (r_idx == ID_W'(ROWS - 1)) r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (!i_sts.pipe_busy) begin
                        r_state <= S_OUT;
                        r_slot  <= ID_W'(i_cnt - CNT_W'(1));
                    end
                end
                S_OUT: begin
                    if (i_sts.out_free) begin
                        if (r_slot == '0) r_state <= S_IDLE;
                        else              r_slot  <= r_slot - 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/rrs_dp.sv
module rrs_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [rrs_pkg::ID_W-1:0]      i_lower_id,
    input  logic [rrs_pkg::ID_W-1:0]      i_upper_id,
    input  logic [rrs_pkg::CNT_W-1:0]     i_cnt,
    input  rrs_pkg::t_cmd                 i_cmd,
    output rrs_pkg::t_sts                 o_sts,
    output logic                          o_m_valid,
    input  logic                          i_m_ready,
    output logic                          o_conform,
    output logic [rrs_pkg::ID_W-1:0]      o_order_candidate,
    output logic                          o_slot_filled,
    output logic                          o_incomplete,
    output logic                          o_last
);
    import rrs_pkg::*;

    // Row memories, two read ports each, registered read data
    logic [ROWS-1:0] r_below_mem [ROWS];
    logic [ROWS-1:0] r_above_mem [ROWS];
    logic [ROWS-1:0] r_below_vld;
    logic [ROWS-1:0] r_above_vld;
    logic [ROWS-1:0] r_present;

    logic [ID_W-1:0] r_lo, r_up;
    logic [ROWS-1:0] r_bqa, r_bqb, r_aqa, r_aqb;
    logic            r_bva, r_bvb, r_ava, r_avb;

    logic [ID_W-1:0] addr_ba, addr_aa;
    logic [ROWS-1:0] below_a, below_b, above_a, above_b;
    logic [ROWS-1:0] add_below, add_above;
    logic            chk_conform;

    // Scan pipeline
    logic             r_v1, r_v2;
    logic [ID_W-1:0]  r_id1, r_id2;
    logic [CNT_W-1:0] r_nb, r_na;
    logic [CNT_W:0]   rel_sum;
    logic             complete;

    // Slot table
    logic [ID_W-1:0] r_slot_id [ROWS];
    logic [ROWS-1:0] r_slot_ok;
    logic            r_inc;

    // Output register
    logic            r_m_valid;
    logic            r_conform, r_filled, r_incomp, r_last;
    logic [ID_W-1:0] r_cand;
    logic            sel_ok;

    // Pair latch
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_lo <= i_lower_id;
            r_up <= i_upper_id;
        end
    end

    // Port A follows the scan index during emit; port B always the pair
    assign addr_ba = i_cmd.scan_sel ? i_cmd.scan_id : i_lower_id;
    assign addr_aa = i_cmd.scan_sel ? i_cmd.scan_id : i_upper_id;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_bqa <= r_below_mem[addr_ba];
            r_bva <= r_below_vld[addr_ba];
            r_bqb <= r_below_mem[i_upper_id];
            r_bvb <= r_below_vld[i_upper_id];
            r_aqa <= r_above_mem[addr_aa];
            r_ava <= r_above_vld[addr_aa];
            r_aqb <= r_above_mem[i_lower_id];
            r_avb <= r_above_vld[i_lower_id];
        end
        if (i_cmd.add_wr) begin
            r_below_mem[r_up] <= add_below;
            r_above_mem[r_lo] <= add_above;
        end
    end

    // Rows never written since the last clear read as zero
    assign below_a = r_bva ? r_bqa : '0;
    assign below_b = r_bvb ? r_bqb : '0;
    assign above_a = r_ava ? r_aqa : '0;
    assign above_b = r_avb ? r_aqb : '0;

    // below[up] |= below[lo] | lo ; above[lo] |= above[up] | up
    assign add_below = below_a | below_b | (ROWS'(1) << r_lo);
    assign add_above = above_a | above_b | (ROWS'(1) << r_up);

    assign chk_conform = !(r_present[r_lo] && r_present[r_up] &&
                           (below_a[r_up] || above_a[r_lo]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_below_vld <= '0;
            r_above_vld <= '0;
            r_present   <= '0;
        end else if (i_cmd.clear) begin
            r_below_vld <= '0;
            r_above_vld <= '0;
            r_present   <= '0;
        end else if (i_cmd.add_wr) begin
            r_below_vld[r_up] <= 1'b1;
            r_above_vld[r_lo] <= 1'b1;
            r_present[r_lo]   <= 1'b1;
            r_present[r_up]   <= 1'b1;
        end
    end

    // Scan: read, count, place
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en && i_cmd.scan_sel;
            r_v2 <= r_v1 && r_present[r_id1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_id1 <= i_cmd.scan_id;
        r_id2 <= r_id1;
        r_nb  <= pop_count(below_a);
        r_na  <= pop_count(above_a);
    end

    assign rel_sum  = {1'b0, r_nb} + {1'b0, r_na} + (CNT_W+1)'(1);
    assign complete = (rel_sum == {1'b0, i_cnt});

    // Ascending scan, so a later (higher) id overwrites a shared slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_ok <= '0;
            r_inc     <= 1'b0;
        end else if (i_cmd.emit_init) begin
            r_slot_ok <= '0;
            r_inc     <= 1'b0;
        end else if (r_v2) begin
            if (complete) r_slot_ok[r_nb[ID_W-1:0]] <= 1'b1;
            else          r_inc <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2 && complete) r_slot_id[r_nb[ID_W-1:0]] <= r_id2;
    end

    // Output register
    assign sel_ok = r_slot_ok[i_cmd.slot];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_chk || i_cmd.out_slot) begin
            r_m_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_chk) begin
            r_conform <= chk_conform;
            r_cand    <= '0;
            r_filled  <= 1'b0;
            r_incomp  <= 1'b0;
            r_last    <= 1'b1;
        end else if (i_cmd.out_slot) begin
            r_conform <= 1'b0;
            r_cand    <= sel_ok ? r_slot_id[i_cmd.slot] : '0;
            r_filled  <= sel_ok;
            r_incomp  <= r_inc;
            r_last    <= i_cmd.slot_last;
        end
    end

    assign o_sts.out_free  = !r_m_valid || i_m_ready;
    assign o_sts.pipe_busy = r_v1 || r_v2;

    assign o_m_valid         = r_m_valid;
    assign o_conform         = r_conform;
    assign o_order_candidate = r_cand;
    assign o_slot_filled     = r_filled;
    assign o_incomplete      = r_incomp;
    assign o_last            = r_last;

endmodule
